[sv/lpg_pkg.sv]
// Shared constants for the line pixel generator.
package lpg_pkg;

   // Extra bits of the Bresenham error term beyond the coordinate width.
   // The term stays within (-2*dy, 2*dx), so two bits of headroom are enough.
   localparam int ERR_GUARD_BITS = 2;

   // Depth of the command queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;

endpackage

[sv/lpg_front.sv]
// Front part: takes line commands and derives deltas, directions and the start error.
module lpg_front #(
   parameter int COORD_BITS = 6,
   localparam int ERR_W = COORD_BITS + lpg_pkg::ERR_GUARD_BITS,
   localparam int CMD_W = 6 * COORD_BITS + 4 + ERR_W
) (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_start_x,
   input  logic [COORD_BITS-1:0] req_start_y,
   input  logic [COORD_BITS-1:0] req_end_x,
   input  logic [COORD_BITS-1:0] req_end_y,
   input  logic                  req_ink,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output logic [CMD_W-1:0]      cmd_data
);
   import lpg_pkg::*;

   logic [COORD_BITS-1:0] delta_x;
   logic [COORD_BITS-1:0] delta_y;
   logic                  step_x_up;
   logic                  step_y_up;
   logic                  zero_len;
   logic [ERR_W-1:0]      err_start;

   // The front does not store anything; the queue behind it takes the beat.
   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;

   // Absolute deltas and step directions along each axis.
   always_comb begin
      if (req_end_x > req_start_x) begin
         delta_x = req_end_x - req_start_x;
      end else begin
         delta_x = req_start_x - req_end_x;
      end
      if (req_end_y > req_start_y) begin
         delta_y = req_end_y - req_start_y;
      end else begin
         delta_y = req_start_y - req_end_y;
      end
      step_x_up = req_start_x < req_end_x;
      step_y_up = req_start_y < req_end_y;
      zero_len  = (req_start_x == req_end_x) && (req_start_y == req_end_y);
      err_start = {{ERR_GUARD_BITS{1'b0}}, delta_x} - {{ERR_GUARD_BITS{1'b0}}, delta_y};
   end

   // Command layout, low to high: start, end, deltas, error, directions, flags.
   assign cmd_data = {req_ink, zero_len, step_x_up, step_y_up, err_start,
                      delta_y, delta_x, req_end_y, req_end_x, req_start_y, req_start_x};

endmodule

[sv/lpg_queue.sv]
// Small first-in first-out queue of command words between the front and back parts.
module lpg_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   import lpg_pkg::*;

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = store_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill count update; pointers wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

[sv/lpg_back.sv]
// Back part: walks one queued line command and emits its pixel writes, one beat per cycle while rsp_ready is high.
module lpg_back #(
   parameter int COORD_BITS = 6,
   localparam int ERR_W = COORD_BITS + lpg_pkg::ERR_GUARD_BITS,
   localparam int CMD_W = 6 * COORD_BITS + 4 + ERR_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  logic [CMD_W-1:0]      cmd_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic                  rsp_pixel_value,
   output logic                  rsp_last
);
   import lpg_pkg::*;

   localparam int CB  = COORD_BITS;
   localparam int E2W = ERR_W + 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_END  = 2'd1;
   localparam logic [1:0] ST_WALK = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CB-1:0] x_ff, x_in, y_ff, y_in;
   logic [CB-1:0] ex_ff, ex_in, ey_ff, ey_in;
   logic [CB-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic          step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic          ink_ff, ink_in, zero_ff, zero_in;
   logic [ERR_W-1:0] err_ff, err_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [CB-1:0] px_ff, px_in, py_ff, py_in;
   logic          pv_ff, pv_in, plast_ff, plast_in;

   logic                  load;
   logic                  out_free;
   logic                  walk_fire;
   logic signed [E2W-1:0] err_w;
   logic signed [E2W-1:0] e2;
   logic signed [E2W-1:0] dx_w;
   logic signed [E2W-1:0] dy_w;
   logic signed [E2W-1:0] err_sum;
   logic                  move_x;
   logic                  move_y;
   logic [CB-1:0]         x_next;
   logic [CB-1:0]         y_next;
   logic                  walk_last;

   assign cmd_ready = state_ff == ST_IDLE;
   assign load      = cmd_valid && cmd_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign walk_fire = (state_ff == ST_WALK) && out_free;

   // One Bresenham step from the current pixel.
   always_comb begin
      err_w  = {err_ff[ERR_W-1], err_ff};
      e2     = {err_ff, 1'b0};
      dx_w   = {{(E2W - CB){1'b0}}, dx_ff};
      dy_w   = {{(E2W - CB){1'b0}}, dy_ff};
      move_x = e2 > -dy_w;
      move_y = e2 < dx_w;
      err_sum = err_w - (move_x ? dy_w : '0) + (move_y ? dx_w : '0);
      x_next = x_ff;
      y_next = y_ff;
      if (move_x) begin
         x_next = step_x_ff ? x_ff + 1'b1 : x_ff - 1'b1;
      end
      if (move_y) begin
         y_next = step_y_ff ? y_ff + 1'b1 : y_ff - 1'b1;
      end
      walk_last = (x_next == ex_ff) && (y_next == ey_ff);
   end

   // Sequencer: load a command, emit the end point, then walk from the start unless the line has zero length.
   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      step_x_in    = step_x_ff;
      step_y_in    = step_y_ff;
      ink_in       = ink_ff;
      zero_in      = zero_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      px_in        = px_ff;
      py_in        = py_ff;
      pv_in        = pv_ff;
      plast_in     = plast_ff;
      case (state_ff)
         ST_IDLE: begin
            if (load) begin
               x_in      = cmd_data[0 +: CB];
               y_in      = cmd_data[CB +: CB];
               ex_in     = cmd_data[2*CB +: CB];
               ey_in     = cmd_data[3*CB +: CB];
               dx_in     = cmd_data[4*CB +: CB];
               dy_in     = cmd_data[5*CB +: CB];
               err_in    = cmd_data[6*CB +: ERR_W];
               step_y_in = cmd_data[6*CB + ERR_W];
               step_x_in = cmd_data[6*CB + ERR_W + 1];
               zero_in   = cmd_data[6*CB + ERR_W + 2];
               ink_in    = cmd_data[6*CB + ERR_W + 3];
               state_in  = ST_END;
            end
         end
         ST_END: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               px_in        = ex_ff;
               py_in        = ey_ff;
               pv_in        = ink_ff;
               plast_in     = zero_ff;
               state_in     = zero_ff ? ST_IDLE : ST_WALK;
            end
         end
         ST_WALK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               px_in        = x_ff;
               py_in        = y_ff;
               pv_in        = ink_ff;
               plast_in     = walk_last;
               x_in         = x_next;
               y_in         = y_next;
               err_in       = err_sum[ERR_W-1:0];
               if (walk_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk registers and the output beat register.
   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      ex_ff     <= ex_in;
      ey_ff     <= ey_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      step_x_ff <= step_x_in;
      step_y_ff <= step_y_in;
      ink_ff    <= ink_in;
      zero_ff   <= zero_in;
      err_ff    <= err_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      pv_ff     <= pv_in;
      plast_ff  <= plast_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = px_ff;
   assign rsp_pixel_y     = py_ff;
   assign rsp_pixel_value = pv_ff;
   assign rsp_last        = plast_ff;

`ifndef SYNTHESIS
   // While walking, the current pixel is never the end point itself.
   a_walk_not_at_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> !((x_ff == ex_ff) && (y_ff == ey_ff)))
      else $error("walk reached the end point without finishing");

   // The error term stays inside its proven range.
   a_err_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> ((err_w >= -(dy_w + dy_w)) && (err_w <= (dx_w + dx_w))))
      else $error("error term out of range");

   // The final walk beat returns the sequencer to idle.
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (walk_fire && walk_last) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after the last beat");
`endif

endmodule

[sv/line_pixel_generator_core.sv]
// Top level of the line pixel generator: front, command queue and walking back end.
//
// Each accepted line command produces max(|dx|, |dy|) + 1 pixel write beats: first the
// end point, then the Bresenham walk from the start point up to the pixel next to the
// end point; the final beat carries rsp_last. A zero-length line yields one beat. The
// back end emits one beat per cycle while rsp_ready is high and goes back to idle to
// load the next command once a line is done. A two-entry command queue lets req_ready
// stay high while the back end is busy with an earlier line, until the queue is full.
module line_pixel_generator_core #(
   parameter int COORD_BITS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_start_x,
   input  logic [COORD_BITS-1:0] req_start_y,
   input  logic [COORD_BITS-1:0] req_end_x,
   input  logic [COORD_BITS-1:0] req_end_y,
   input  logic                  req_ink,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic                  rsp_pixel_value,
   output logic                  rsp_last
);
   import lpg_pkg::*;

   localparam int ERR_W = COORD_BITS + ERR_GUARD_BITS;
   localparam int CMD_W = 6 * COORD_BITS + 4 + ERR_W;

   logic             front_valid;
   logic             front_ready;
   logic [CMD_W-1:0] front_data;
   logic             back_valid;
   logic             back_ready;
   logic [CMD_W-1:0] back_data;

   // Command classification.
   lpg_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .req_ink     (req_ink),
      .cmd_valid   (front_valid),
      .cmd_ready   (front_ready),
      .cmd_data    (front_data)
   );

   // Queue decoupling the front from the walking back end.
   lpg_queue #(
      .WIDTH(CMD_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_data  (back_data)
   );

   // Pixel walk and output beat register.
   lpg_back #(
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (back_valid),
      .cmd_ready       (back_ready),
      .cmd_data        (back_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_last        (rsp_last)
   );

endmodule

[test/testbench.sv]
// Self-checking testbench for the line pixel generator core.
module testbench;

   localparam int COORD_BITS    = 6;
   localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
   localparam int DRAIN_CYCLES  = 80;
   localparam int IDLE_LIMIT    = 5000;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_LINES  = 220;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct {
      coord_type x;
      coord_type y;
      logic      value;
      logic      last;
   } pixel_beat_type;

   // Kinds of random line used in the random test.
   typedef enum int {
      LINE_ANY,
      LINE_SHORT,
      LINE_AXIS,
      LINE_POINT
   } line_kind_type;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   coord_type req_start_x;
   coord_type req_start_y;
   coord_type req_end_x;
   coord_type req_end_y;
   logic      req_ink;
   logic      rsp_valid;
   logic      rsp_ready;
   coord_type rsp_pixel_x;
   coord_type rsp_pixel_y;
   logic      rsp_pixel_value;
   logic      rsp_last;

   pixel_beat_type expected_pixels[$];
   int             lines_sent;
   int             pixels_checked;
   int             mismatches;
   int             input_stall_cycles;
   int             idle_cycles;
   int             hold_off_cycles;
   bit             hold_active;
   bit             send_gaps_on;
   bit             rsp_stalls_on;

   line_pixel_generator_core #(
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .req_ink        (req_ink),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_pixel_value(rsp_pixel_value),
      .rsp_last       (rsp_last)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Gap length: mostly none, sometimes short, rarely a long pause.
   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Rasterize one line and queue the pixel beats the block must produce.
   // The end point leads, then the error-term walk from the start point stops
   // one pixel short of the end point.
   task automatic predict_line_pixels(input coord_type sx0, input coord_type sy0,
                                      input coord_type ex0, input coord_type ey0,
                                      input logic ink);
      int             x, y, ex, ey, dx, dy, step_x, step_y, err, e2, count;
      pixel_beat_type beat;
      x  = int'(sx0);
      y  = int'(sy0);
      ex = int'(ex0);
      ey = int'(ey0);
      dx = (ex > x) ? ex - x : x - ex;
      dy = (ey > y) ? ey - y : y - ey;
      step_x = (x < ex) ? 1 : -1;
      step_y = (y < ey) ? 1 : -1;
      err = dx - dy;
      beat.x     = coord_type'(ex);
      beat.y     = coord_type'(ey);
      beat.value = ink;
      beat.last  = (x == ex && y == ey);
      expected_pixels.push_back(beat);
      count = 1;
      while ((x != ex || y != ey) && count < (1 << COORD_BITS)) begin
         e2 = err * 2;
         beat.x    = coord_type'(x);
         beat.y    = coord_type'(y);
         beat.last = 1'b0;
         expected_pixels.push_back(beat);
         count++;
         if (e2 > -dy) begin
            err -= dy;
            x += step_x;
         end
         if (e2 < dx) begin
            err += dx;
            y += step_y;
         end
      end
      expected_pixels[expected_pixels.size() - 1].last = 1'b1;
   endtask

   // Offer one line command and hold it until the block takes the beat.
   task automatic send_line(input int sx, input int sy, input int ex,
                            input int ey, input logic ink);
      int gap;
      gap = send_gaps_on ? idle_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_start_x <= coord_type'(sx);
      req_start_y <= coord_type'(sy);
      req_end_x   <= coord_type'(ex);
      req_end_y   <= coord_type'(ey);
      req_ink     <= ink;
      predict_line_pixels(coord_type'(sx), coord_type'(sy), coord_type'(ex),
                          coord_type'(ey), ink);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      lines_sent++;
   endtask

   // Drop the request valid after the last command of a test.
   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Wait until every queued pixel has come back, then let the back end settle.
   task automatic wait_drain();
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Pick a random coordinate within three of a base value, kept on the grid.
   function automatic coord_type near(input int base);
      int lo, hi;
      lo = (base < 3) ? 0 : base - 3;
      hi = (base > COORD_MAX - 3) ? COORD_MAX : base + 3;
      return coord_type'($urandom_range(lo, hi));
   endfunction

   task automatic send_random_line(input line_kind_type kind);
      coord_type sx, sy, ex, ey;
      sx = coord_type'($urandom_range(0, COORD_MAX));
      sy = coord_type'($urandom_range(0, COORD_MAX));
      ex = coord_type'($urandom_range(0, COORD_MAX));
      ey = coord_type'($urandom_range(0, COORD_MAX));
      case (kind)
         LINE_SHORT: begin
            ex = near(int'(sx));
            ey = near(int'(sy));
         end
         LINE_AXIS: begin
            if ($urandom_range(0, 1)) ex = sx;
            else ey = sy;
         end
         LINE_POINT: begin
            ex = sx;
            ey = sy;
         end
         default: ;
      endcase
      send_line(int'(sx), int'(sy), int'(ex), int'(ey), 1'($urandom_range(0, 1)));
   endtask

   function automatic line_kind_type random_kind();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return LINE_ANY;
      if (pick < 85) return LINE_SHORT;
      if (pick < 95) return LINE_AXIS;
      return LINE_POINT;
   endfunction

   // Corner coordinates, every octant, axis lines, single steps and zero length.
   task automatic test_directed_lines();
      send_line(0, 0, 0, 0, 1'b1);
      send_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
      send_line(0, 0, COORD_MAX, 0, 1'b1);
      send_line(COORD_MAX, 5, 0, 5, 1'b0);
      send_line(7, 0, 7, COORD_MAX, 1'b1);
      send_line(9, COORD_MAX, 9, 0, 1'b1);
      send_line(0, 0, COORD_MAX, COORD_MAX, 1'b1);
      send_line(COORD_MAX, COORD_MAX, 0, 0, 1'b0);
      send_line(COORD_MAX, 0, 0, COORD_MAX, 1'b1);
      send_line(0, COORD_MAX, COORD_MAX, 0, 1'b0);
      send_line(10, 10, 13, 40, 1'b1);
      send_line(10, 10, 40, 13, 1'b1);
      send_line(40, 10, 5, 12, 1'b0);
      send_line(40, 10, 38, 50, 1'b1);
      send_line(30, 50, 33, 2, 1'b1);
      send_line(30, 50, 60, 47, 1'b0);
      send_line(50, 50, 2, 45, 1'b1);
      send_line(50, 50, 45, 1, 1'b0);
      send_line(5, 5, 6, 5, 1'b1);
      send_line(5, 5, 5, 4, 1'b1);
      send_line(5, 5, 6, 6, 1'b0);
      send_line(0, COORD_MAX, 1, 0, 1'b1);
      stop_sending();
   endtask

   // The bulk of the run: random lines with idling on both channels.
   task automatic test_random_lines();
      repeat (RANDOM_LINES) send_random_line(random_kind());
      stop_sending();
   endtask

   // No idling on either side for a stretch of back-to-back commands.
   task automatic test_back_to_back();
      send_gaps_on  = 1'b0;
      rsp_stalls_on = 1'b0;
      repeat (40) send_random_line(random_kind());
      stop_sending();
      send_gaps_on  = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // The receiver holds off long enough for the command queue to fill and the
   // block to drop req_ready while commands keep coming.
   task automatic test_queue_full();
      send_gaps_on    = 1'b0;
      hold_off_cycles = HOLD_CYCLES;
      while (!hold_active) @(posedge clock);
      repeat (8) send_random_line(LINE_ANY);
      stop_sending();
      send_gaps_on = 1'b1;
   endtask

   // The sender stops until every pending pixel has arrived, then resumes.
   task automatic test_drain_pause();
      repeat (6) send_random_line(random_kind());
      stop_sending();
      wait_drain();
      repeat (6) send_random_line(random_kind());
      stop_sending();
   endtask

   // Receiver: random ready with gaps, or a long hold-off counted here.
   initial begin
      int gap;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ready  <= 1'b0;
            hold_active = 1'b1;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
            hold_active     = 1'b0;
         end else if (!rsp_stalls_on || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            gap = idle_gap();
            repeat (gap) @(negedge clock);
         end
      end
   end

   task automatic report_field(input string field, input int expected, input int actual);
      if (expected != actual) begin
         $display("%0t: pixel %0d field %s expected %0d actual %0d",
                  $time, pixels_checked, field, expected, actual);
         mismatches++;
      end
   endtask

   // Compare every accepted pixel beat with the oldest prediction.
   always @(posedge clock) begin
      pixel_beat_type want;
      if (!reset && req_valid && !req_ready) input_stall_cycles++;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: expected no pixel beat, actual x %0d y %0d value %0d last %0d",
                     $time, rsp_pixel_x, rsp_pixel_y, rsp_pixel_value, rsp_last);
            mismatches++;
         end else begin
            want = expected_pixels.pop_front();
            report_field("pixel_x", int'(want.x), int'(rsp_pixel_x));
            report_field("pixel_y", int'(want.y), int'(rsp_pixel_y));
            report_field("pixel_value", int'(want.value), int'(rsp_pixel_value));
            report_field("last", int'(want.last), int'(rsp_last));
         end
         pixels_checked++;
      end
   end

   // Watchdog: end the run when no beat moves on either channel for too long.
   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("%0t: no beat accepted for %0d cycles, %0d pixels still expected",
               $time, IDLE_LIMIT, expected_pixels.size());
      $display("testbench NOT OK");
      $finish;
   end

   // Reset, then the tests in turn, then the verdict.
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_start_x     = '0;
      req_start_y     = '0;
      req_end_x       = '0;
      req_end_y       = '0;
      req_ink         = 1'b0;
      lines_sent      = 0;
      pixels_checked  = 0;
      mismatches      = 0;
      input_stall_cycles = 0;
      hold_off_cycles = 0;
      hold_active     = 1'b0;
      send_gaps_on    = 1'b1;
      rsp_stalls_on   = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_lines();
      test_random_lines();
      test_back_to_back();
      test_queue_full();
      test_drain_pause();
      wait_drain();

      $display("Covered %0d line commands and %0d pixel beats, with %0d cycles of input stall.",
               lines_sent, pixels_checked, input_stall_cycles);
      $display("Lines included all octants, axis lines, zero length and full-grid diagonals.");
      if (mismatches == 0) begin
         $display("testbench OK");
      end else begin
         $display("%0d mismatches found", mismatches);
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

[files.f]
sv/lpg_pkg.sv
sv/lpg_front.sv
sv/lpg_queue.sv
sv/lpg_back.sv
sv/line_pixel_generator_core.sv
test/testbench.sv
